/* hdl/frs_pkg.sv */
// Shared types and constants for the Fenwick range sum core.
package frs_pkg;

  localparam int POS_W        = 11;
  localparam int IDX_W        = POS_W + 1;
  localparam int DATA_W       = 32;
  localparam int SUM_W        = 64;
  localparam int DEFAULT_SIZE = 1024;
  localparam int POS_MAX      = (1 << POS_W) - 1;

  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_HI,
    ST_Q_LO,
    ST_Q_OUT
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic load_add;
    logic load_query;
    logic add_rd;
    logic add_wr;
    logic q_rd;
    logic q_sub;
    logic q_switch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_zero;
    logic add_live;
    logic out_busy;
  } status_t;

endpackage

/* hdl/fenwick_range_sum_core.sv */
// Fenwick range sum core: binary indexed tree with add and range query transactions.
// An add reads and writes each node on its upward chain; the chain holds at most
// log2(SIZE)+1 nodes.
// A query reads one node per cycle on each of its two downward chains through the
// RAM's single read port.
// After reset the node RAM is swept to zero, one entry a cycle, over min(SIZE, 2047)
// entries; input transactions are stalled meanwhile, size writes are taken throughout.
module fenwick_range_sum_core #(
  parameter int SIZE = frs_pkg::DEFAULT_SIZE
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic        [frs_pkg::POS_W-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic        [frs_pkg::POS_W-1:0]   first_index_i,
  input  logic        [frs_pkg::POS_W-1:0]   last_index_i,
  input  logic signed [frs_pkg::DATA_W-1:0]  delta_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [frs_pkg::SUM_W-1:0]   range_sum_o
);

  frs_pkg::cmd_t    cmd;
  frs_pkg::status_t status;

  frs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  frs_datapath #(
    .SIZE (SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .first_index_i (first_index_i),
    .last_index_i  (last_index_i),
    .delta_i       (delta_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_sum_o   (range_sum_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

/* hdl/frs_ram.sv */
// Generic simple dual-port RAM with registered read data.
module frs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/frs_ctrl.sv */
// Controller state machine sequencing clear, add and query walks.
module frs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             opcode_i,
  output logic             in_stall_o,
  input  frs_pkg::status_t status_i,
  output frs_pkg::cmd_t    cmd_o
);

  frs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      frs_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = frs_pkg::ST_IDLE;
        end
      end
      frs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (opcode_i == frs_pkg::OP_QUERY) begin
            cmd_o.load_query = 1'b1;
            state_d          = frs_pkg::ST_Q_HI;
          end else begin
            cmd_o.load_add = 1'b1;
            state_d        = frs_pkg::ST_ADD_RD;
          end
        end
      end
      frs_pkg::ST_ADD_RD: begin
        // drop out once the upward chain leaves the covered range
        if (status_i.add_live) begin
          cmd_o.add_rd = 1'b1;
          state_d      = frs_pkg::ST_ADD_WR;
        end else begin
          state_d = frs_pkg::ST_IDLE;
        end
      end
      frs_pkg::ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = frs_pkg::ST_ADD_RD;
      end
      frs_pkg::ST_Q_HI: begin
        if (status_i.idx_zero) begin
          cmd_o.q_switch = 1'b1;
          state_d        = frs_pkg::ST_Q_LO;
        end else begin
          cmd_o.q_rd = 1'b1;
        end
      end
      frs_pkg::ST_Q_LO: begin
        if (status_i.idx_zero) begin
          state_d = frs_pkg::ST_Q_OUT;
        end else begin
          cmd_o.q_rd  = 1'b1;
          cmd_o.q_sub = 1'b1;
        end
      end
      frs_pkg::ST_Q_OUT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = frs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = frs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/frs_datapath.sv */
// Datapath: size register, index walker, node RAM, accumulator and result register.
module frs_datapath #(
  parameter int SIZE = frs_pkg::DEFAULT_SIZE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [frs_pkg::POS_W-1:0]    cfg_wdata_i,
  input  logic        [frs_pkg::POS_W-1:0]    first_index_i,
  input  logic        [frs_pkg::POS_W-1:0]    last_index_i,
  input  logic signed [frs_pkg::DATA_W-1:0]   delta_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [frs_pkg::SUM_W-1:0]    range_sum_o,
  input  frs_pkg::cmd_t                       cmd_i,
  output frs_pkg::status_t                    status_o
);

  localparam int POS_W  = frs_pkg::POS_W;
  localparam int IDX_W  = frs_pkg::IDX_W;
  localparam int DATA_W = frs_pkg::DATA_W;
  localparam int SUM_W  = frs_pkg::SUM_W;
  // positions beyond what the index fields can name are never reached
  localparam int DEPTH  = (SIZE < frs_pkg::POS_MAX) ? SIZE : frs_pkg::POS_MAX;
  localparam int AW     = $clog2(DEPTH);

  logic [POS_W-1:0]  size_q;
  logic [POS_W-1:0]  n_cov;
  logic [POS_W-1:0]  first_c, last_c, lo_start;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  idx_m1, low_bit;
  logic [POS_W-1:0]  lo_q;
  logic [DATA_W-1:0] delta_q;
  logic [AW-1:0]     clr_q;
  logic [SUM_W-1:0]  acc_q, acc_d, node_ext;
  logic              pend_q, sub_q;
  logic              out_valid_q;
  logic [SUM_W-1:0]  result_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, node_addr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  function automatic logic [POS_W-1:0] clamp_pos(logic [POS_W-1:0] p, logic [POS_W-1:0] n);
    return (p > n) ? n : p;
  endfunction

  always_comb begin
    if (size_q == '0) begin
      n_cov = POS_W'(1);
    end else if (32'(size_q) > 32'(DEPTH)) begin
      n_cov = POS_W'(DEPTH);
    end else begin
      n_cov = size_q;
    end
  end

  assign first_c  = clamp_pos(first_index_i, n_cov);
  assign last_c   = clamp_pos(last_index_i, n_cov);
  // a left end of zero counts as one, so the low prefix starts at zero
  assign lo_start = (first_c == '0) ? '0 : first_c - POS_W'(1);

  assign idx_m1    = idx_q - IDX_W'(1);
  assign low_bit   = idx_q & (~idx_q + IDX_W'(1));
  assign node_addr = idx_m1[AW-1:0];
  assign node_ext  = {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_add) begin
      idx_d = {1'b0, first_c};
    end else if (cmd_i.load_query) begin
      idx_d = {1'b0, last_c};
    end else if (cmd_i.add_wr) begin
      idx_d = idx_q + low_bit;
    end else if (cmd_i.q_rd) begin
      idx_d = idx_q & idx_m1;
    end else if (cmd_i.q_switch) begin
      idx_d = {1'b0, lo_q};
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load_query) begin
      acc_d = '0;
    end else if (pend_q) begin
      acc_d = sub_q ? acc_q - node_ext : acc_q + node_ext;
    end
  end

  always_comb begin
    ram_we    = cmd_i.clr_wr | cmd_i.add_wr;
    ram_waddr = cmd_i.clr_wr ? clr_q : node_addr;
    ram_wdata = cmd_i.clr_wr ? '0 : ram_rdata + delta_q;
    ram_re    = cmd_i.add_rd | cmd_i.q_rd;
  end

  frs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (node_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= frs_pkg::SIZE_RESET;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      pend_q <= cmd_i.q_rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    acc_q <= acc_d;
    sub_q <= cmd_i.q_sub;
    if (cmd_i.load_add) begin
      delta_q <= delta_i;
    end
    if (cmd_i.load_query) begin
      lo_q <= lo_start;
    end
    if (cmd_i.out_load) begin
      result_q <= acc_q;
    end
  end

  assign status_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign status_o.idx_zero = (idx_q == '0);
  assign status_o.add_live = (idx_q != '0) && (idx_q <= {1'b0, n_cov});
  assign status_o.out_busy = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign range_sum_o = result_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Fenwick range sum core: adds, range queries, size writes.
module testbench;

  localparam int POS_W       = frs_pkg::POS_W;
  localparam int DATA_W      = frs_pkg::DATA_W;
  localparam int SUM_W       = frs_pkg::SUM_W;
  localparam int POS_MAX     = frs_pkg::POS_MAX;
  localparam int TREE_DEPTH  = frs_pkg::DEFAULT_SIZE;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 60;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [POS_W-1:0]         cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     opcode_i;
  logic [POS_W-1:0]         first_index_i;
  logic [POS_W-1:0]         last_index_i;
  logic signed [DATA_W-1:0] delta_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [SUM_W-1:0]  range_sum_o;

  fenwick_range_sum_core #(.SIZE(TREE_DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .first_index_i (first_index_i),
    .last_index_i  (last_index_i),
    .delta_i       (delta_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .range_sum_o   (range_sum_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Tree mirror and pending sums
  logic [DATA_W-1:0] node_store [1:TREE_DEPTH];
  logic [POS_W-1:0]  size_reg;
  logic [SUM_W-1:0]  sum_expect_q [$];

  int  mismatch_count;
  int  cycle_count;
  int  add_count;
  int  query_count;
  int  sums_checked;
  int  size_writes;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  rx_hold_req;

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] exp_v,
                                 input logic [SUM_W-1:0] got_v);
    if (mismatch_count < 30)
      $display("MISMATCH cycle %0d: %s expected %h got %h", cycle_count, what, exp_v, got_v);
    mismatch_count++;
  endtask

  function automatic int unsigned covered_size();
    int unsigned n;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > TREE_DEPTH) n = TREE_DEPTH;
    return n;
  endfunction

  function automatic int unsigned lowest_bit(input int unsigned v);
    return v & (~v + 1);
  endfunction

  function automatic logic [SUM_W-1:0] prefix_total(input int unsigned pos);
    logic [SUM_W-1:0] acc;
    int unsigned      i;
    acc = '0;
    i = pos;
    while (i != 0) begin
      acc += {{(SUM_W-DATA_W){node_store[i][DATA_W-1]}}, node_store[i]};
      i -= lowest_bit(i);
    end
    return acc;
  endfunction

  // Mirror one accepted transaction; queries push their expected sum
  task automatic predict_transaction(input logic op, input logic [POS_W-1:0] first,
                                     input logic [POS_W-1:0] last, input logic [DATA_W-1:0] d);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    n  = covered_size();
    lo = (first > n) ? n : first;
    hi = (last > n) ? n : last;
    if (op == frs_pkg::OP_ADD) begin
      add_count++;
      i = lo;
      while (i != 0 && i <= n) begin
        node_store[i] += d;
        i += lowest_bit(i);
      end
    end else begin
      query_count++;
      if (lo == 0) lo = 1;
      sum_expect_q.push_back(prefix_total(hi) - prefix_total(lo - 1));
    end
  endtask

  task automatic send_item(input logic op, input logic [POS_W-1:0] first,
                           input logic [POS_W-1:0] last, input logic [DATA_W-1:0] d);
    bit taken;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    first_index_i <= first;
    last_index_i  <= last;
    delta_i       <= d;
    // stall is settled by the falling edge; the transaction lands on the next rise
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    predict_transaction(op, first, last, d);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sum_expect_q.size() != 0) @(posedge clk_i);
    // an add may still be walking its chain
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [POS_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = value;
    size_writes++;
  endtask

  function automatic logic [POS_W-1:0] pick_position(input int unsigned n);
    case ($urandom_range(0, 5))
      0, 1:    return POS_W'($urandom_range(0, POS_MAX));
      2, 3:    return POS_W'($urandom_range(1, n));
      4:       return POS_W'(n);
      default: return POS_W'($urandom_range(0, 2));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_delta();
    case ($urandom_range(0, 4))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 200) - 100;
      default: begin
        case ($urandom_range(0, 2))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned n;
    n = covered_size();
    send_item($urandom_range(0, 1) ? frs_pkg::OP_QUERY : frs_pkg::OP_ADD,
              pick_position(n), pick_position(n), pick_delta());
  endtask

  // Receiver: random stall bursts, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker: sample at the falling edge, the transaction completes at the next rise
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sum_expect_q.size() == 0) begin
        report_mismatch("unexpected range_sum", '0, range_sum_o);
      end else begin
        if (range_sum_o !== sum_expect_q[0])
          report_mismatch("range_sum", sum_expect_q[0], range_sum_o);
        void'(sum_expect_q.pop_front());
        sums_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sums outstanding", cycle_count,
               sum_expect_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed_cases();
    write_size(frs_pkg::SIZE_RESET);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd1024, '0);
    send_item(frs_pkg::OP_ADD, 11'd1, '0, 32'h7fff_ffff);
    send_item(frs_pkg::OP_ADD, 11'd1024, '0, 32'h8000_0000);
    send_item(frs_pkg::OP_ADD, 11'd0, '0, 32'd5);
    send_item(frs_pkg::OP_ADD, 11'd2047, 11'd2047, 32'd3);
    send_item(frs_pkg::OP_ADD, 11'd512, '0, 32'hffff_ffff);
    send_item(frs_pkg::OP_ADD, 11'd1, '0, 32'h7fff_ffff);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd1, '0);
    send_item(frs_pkg::OP_QUERY, 11'd0, 11'd1024, '0);
    send_item(frs_pkg::OP_QUERY, 11'd5, 11'd0, '0);
    send_item(frs_pkg::OP_QUERY, 11'd10, 11'd3, 32'hffff_ffff);
    send_item(frs_pkg::OP_QUERY, 11'd4, 11'd3, '0);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd2047, '0);
    send_item(frs_pkg::OP_QUERY, 11'd2047, 11'd2047, '0);
    send_item(frs_pkg::OP_QUERY, 11'd512, 11'd512, '0);
    send_item(frs_pkg::OP_QUERY, 11'd0, 11'd0, '0);
    send_item(frs_pkg::OP_ADD, 11'd7, 11'd1024, 32'd123);
    send_item(frs_pkg::OP_QUERY, 11'd7, 11'd7, '0);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd1024, '0);
  endtask

  task automatic test_size_extremes();
    write_size(11'd1);
    send_item(frs_pkg::OP_ADD, 11'd1, '0, 32'd9);
    send_item(frs_pkg::OP_ADD, 11'd5, '0, 32'd4);
    send_item(frs_pkg::OP_QUERY, 11'd0, 11'd2047, '0);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd1, '0);
    write_size(11'd0);
    send_item(frs_pkg::OP_ADD, 11'd1, '0, 32'hffff_fff0);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd1, '0);
    // nodes stay as stored when the size grows again
    write_size(11'd2047);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd1024, '0);
    send_item(frs_pkg::OP_QUERY, 11'd2, 11'd1023, '0);
    write_size(11'd3);
    send_item(frs_pkg::OP_QUERY, 11'd1, 11'd3, '0);
    send_item(frs_pkg::OP_ADD, 11'd3, '0, 32'd77);
    send_item(frs_pkg::OP_QUERY, 11'd2, 11'd3, '0);
  endtask

  task automatic test_random_phases();
    logic [POS_W-1:0] sizes [10];
    sizes = '{11'd1024, 11'd7, 11'd1, 11'd2047, 11'd0, 11'd300, 11'd64, 11'd2, 11'd1000,
              11'd1024};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      // every third phase runs without any idling
      tx_idle_on = (p % 3 != 2);
      rx_idle_on = (p % 3 != 2);
      repeat (150) send_random_item();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_output_hold_off();
    write_size(11'd1024);
    rx_hold_req = 1'b1;
    // keep offering queries so the core backs up into its input
    repeat (60)
      send_item(frs_pkg::OP_QUERY, pick_position(1024), pick_position(1024), pick_delta());
    repeat (40) send_random_item();
  endtask

  task automatic test_full_rate_tail();
    write_size(11'd1024);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (300) send_random_item();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    opcode_i      <= frs_pkg::OP_ADD;
    first_index_i <= '0;
    last_index_i  <= '0;
    delta_i       <= '0;
    out_stall_i   <= 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    add_count      = 0;
    query_count    = 0;
    sums_checked   = 0;
    size_writes    = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    rx_hold_req    = 1'b0;
    size_reg       = frs_pkg::SIZE_RESET;
    foreach (node_store[i]) node_store[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_size_extremes();
    test_random_phases();
    test_output_hold_off();
    test_full_rate_tail();

    drain_results();
    foreach (sum_expect_q[i])
      report_mismatch("missing range_sum", sum_expect_q[i], '0);
    $display("summary: %0d adds and %0d range queries over %0d size settings",
             add_count, query_count, size_writes);
    $display("summary: %0d sums compared, %0d mismatches", sums_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
